### hdl/audio_record_playback_buffer_unit_defines.svh
// Assertion macros shared by the record/playback buffer RTL.
`ifndef AUDIO_RECORD_PLAYBACK_BUFFER_UNIT_DEFINES_SVH
`define AUDIO_RECORD_PLAYBACK_BUFFER_UNIT_DEFINES_SVH

// Checked on every rising edge, off while reset is asserted.
`define ARPB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define ARPB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/arpb_pkg.sv
// Package of the record/playback buffer: sizes, codes and stage types.
`default_nettype none

package arpb_pkg;

  localparam int unsigned STORE_DEPTH = 65536;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int unsigned POS_W       = 17;
  localparam int unsigned SAMPLE_W    = 12;
  localparam int unsigned LEVEL_W     = 8;
  localparam int unsigned SHIFT       = 4;
  localparam int unsigned IN_DATA_W   = 16;
  localparam int unsigned OUT_DATA_W  = 48;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STORE_DEPTH);

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_REC  = 2'd1,
    ACT_STOP = 2'd2,
    ACT_PLAY = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_REC  = 2'd1,
    MODE_PLAY = 2'd2
  } mode_t;

  // Result fields carried alongside the store read.
  typedef struct packed {
    mode_t             mode;
    logic [CNT_W-1:0]  pos;
    logic [CNT_W-1:0]  len;
    logic              ended;
    logic              play;
  } stage_t;

  function automatic logic [POS_W-1:0] to_pos(input logic [CNT_W-1:0] v);
    return POS_W'(v);
  endfunction

endpackage

`default_nettype wire

### hdl/arpb_sample_ram.sv
// Single-port sample store with registered read data.
`default_nettype none

module arpb_sample_ram #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

### hdl/audio_record_playback_buffer_unit.sv
// Top level of the record/playback buffer: mode control, store access, output stage.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+------------------------------------------
//  in_     | in  | in_tvalid / in_tready  | tdata adc_sample, tuser action
//  out_    | out | out_tvalid / out_tready| tdata level,mode,position,length; tlast ended
//
// One beat in per cycle while in_tready is high; each result passes the store read and s1,
// then the output reg. At the input beat mode, position and length update and the store is
// read or written at the old position, so a later beat always sees an earlier write.
// Reset clears mode, position and length at once; the store needs no clearing pass.
// Two result slots: input is taken while one finished result waits on out_tready.
`default_nettype none
`include "audio_record_playback_buffer_unit_defines.svh"

module audio_record_playback_buffer_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [arpb_pkg::IN_DATA_W-1:0]   in_tdata,   // [11:0] adc_sample
  input  wire logic [1:0]                       in_tuser,   // [1:0] action
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [7:0] dac_level, [9:8] mode, [26:10] position, [43:27] recorded_length
  output logic      [arpb_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                                  out_tlast   // ended
);

  arpb_pkg::mode_t                 mode_r, mode_nxt;
  logic [arpb_pkg::CNT_W-1:0]      pos_r, pos_nxt;
  logic [arpb_pkg::CNT_W-1:0]      len_r, len_nxt;
  logic [arpb_pkg::CNT_W-1:0]      pos_inc;
  arpb_pkg::action_t               action;
  logic                            in_accept;
  logic                            ended;
  logic                            wr_en;
  logic                            rd_en;
  logic [arpb_pkg::LEVEL_W-1:0]    ram_q;
  logic [arpb_pkg::LEVEL_W-1:0]    wr_level;

  logic                            s1_valid_r, s1_valid_nxt;
  arpb_pkg::stage_t                s1_r;
  logic                            o_valid_r, o_valid_nxt;
  logic                            o_load;
  arpb_pkg::stage_t                o_r;
  logic [arpb_pkg::LEVEL_W-1:0]    o_level_r;

  assign action    = arpb_pkg::action_t'(in_tuser);
  assign in_tready = !s1_valid_r || !o_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;
  assign pos_inc   = pos_r + 1'b1;
  assign wr_level  = in_tdata[arpb_pkg::SAMPLE_W-1:arpb_pkg::SHIFT];

  // next state
  always_comb begin
    mode_nxt = mode_r;
    pos_nxt  = pos_r;
    len_nxt  = len_r;
    if (in_accept) begin
      case (action)
        arpb_pkg::ACT_TICK: begin
          if (mode_r == arpb_pkg::MODE_REC) begin
            pos_nxt = pos_inc;
            if (pos_inc == arpb_pkg::DEPTH_CNT) begin
              len_nxt  = pos_inc;
              mode_nxt = arpb_pkg::MODE_IDLE;
            end
          end else if (mode_r == arpb_pkg::MODE_PLAY) begin
            pos_nxt = pos_inc;
            if (pos_inc >= len_r) begin
              mode_nxt = arpb_pkg::MODE_IDLE;
            end
          end
        end
        arpb_pkg::ACT_REC: begin
          if (mode_r == arpb_pkg::MODE_IDLE) begin
            pos_nxt  = '0;
            len_nxt  = '0;
            mode_nxt = arpb_pkg::MODE_REC;
          end
        end
        arpb_pkg::ACT_STOP: begin
          if (mode_r == arpb_pkg::MODE_REC) begin
            len_nxt  = pos_r;
            mode_nxt = arpb_pkg::MODE_IDLE;
          end
        end
        arpb_pkg::ACT_PLAY: begin
          if (mode_r == arpb_pkg::MODE_IDLE && len_r != '0) begin
            pos_nxt  = '0;
            mode_nxt = arpb_pkg::MODE_PLAY;
          end
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end
  end

  // outputs of the step
  always_comb begin
    wr_en = 1'b0;
    rd_en = 1'b0;
    ended = 1'b0;
    if (in_accept) begin
      case (action)
        arpb_pkg::ACT_TICK: begin
          wr_en = (mode_r == arpb_pkg::MODE_REC);
          rd_en = (mode_r == arpb_pkg::MODE_PLAY);
          ended = (mode_r != arpb_pkg::MODE_IDLE) && (mode_nxt == arpb_pkg::MODE_IDLE);
        end
        arpb_pkg::ACT_STOP: begin
          ended = (mode_r == arpb_pkg::MODE_REC);
        end
        default: begin
          ended = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= arpb_pkg::MODE_IDLE;
      pos_r  <= '0;
      len_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      len_r  <= len_nxt;
    end
  end

  // record and play never touch the store in the same step
  arpb_sample_ram #(
    .DEPTH (arpb_pkg::STORE_DEPTH),
    .WIDTH (arpb_pkg::LEVEL_W)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .re    (rd_en),
    .addr  (pos_r[arpb_pkg::ADDR_W-1:0]),
    .wdata (wr_level),
    .rdata (ram_q)
  );

  // s1 waits on the store read; o is the output register
  assign o_load = s1_valid_r && (!o_valid_r || out_tready);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (o_load) begin
      s1_valid_nxt = 1'b0;
    end
    o_valid_nxt = o_valid_r;
    if (o_load) begin
      o_valid_nxt = 1'b1;
    end else if (out_tready) begin
      o_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      o_valid_r  <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_r.mode  <= mode_nxt;
      s1_r.pos   <= pos_nxt;
      s1_r.len   <= len_nxt;
      s1_r.ended <= ended;
      s1_r.play  <= rd_en;
    end
    if (o_load) begin
      o_r       <= s1_r;
      o_level_r <= s1_r.play ? ram_q : '0;
    end
  end

  assign out_tvalid = o_valid_r;
  assign out_tlast  = o_r.ended;
  assign out_tdata  = {4'b0, arpb_pkg::to_pos(o_r.len), arpb_pkg::to_pos(o_r.pos),
                       o_r.mode, o_level_r};

  `ARPB_ASSERT(a_no_rd_wr, !(wr_en && rd_en), "store read and write in one step")
  `ARPB_ASSERT(a_s1_drains, s1_valid_r && !o_valid_r |=> o_valid_r, "s1 did not drain")
  `ARPB_ASSERT(a_rec_in_range, mode_r == arpb_pkg::MODE_REC |-> pos_r < arpb_pkg::DEPTH_CNT,
               "record position past store end")
  `ARPB_ASSERT(a_play_in_range, mode_r == arpb_pkg::MODE_PLAY |-> pos_r < len_r,
               "play position past recorded length")
  `ARPB_ASSERT(a_end_idle, o_valid_r && o_r.ended |-> o_r.mode == arpb_pkg::MODE_IDLE,
               "end flagged while not idle")

endmodule

`default_nettype wire
